@@ sv/touch_detect_with_baseline_tracking_assert.svh @@
// ----------------------------------------------------------------------------
// Touch detector assertion macros
// Concurrent assertion wrappers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TOUCH_DETECT_WITH_BASELINE_TRACKING_ASSERT_SVH
`define TOUCH_DETECT_WITH_BASELINE_TRACKING_ASSERT_SVH

`ifndef SYNTHESIS
// Consequent must hold in the cycle after the antecedent.
`define TDBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
// Consequent must hold in the same cycle as the antecedent.
`define TDBT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define TDBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define TDBT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ sv/tdbt_pkg.sv @@
// ----------------------------------------------------------------------------
// Touch detector package
// Widths, register indices, reset values and the shared payload types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdbt_pkg;

  localparam int SAMPLE_BITS = 22;
  localparam int MARGIN_W    = 16;
  localparam int RUN_W       = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = (SAMPLE_BITS > MARGIN_W) ? SAMPLE_BITS : MARGIN_W;

  localparam logic [MARGIN_W-1:0]    TOUCH_MARGIN_RST   = MARGIN_W'(983);
  localparam logic [MARGIN_W-1:0]    RELEASE_MARGIN_RST = MARGIN_W'(655);
  localparam logic [RUN_W-1:0]       CONFIRM_FRAMES_RST = RUN_W'(6);
  localparam logic [SAMPLE_BITS-1:0] DETECT_FLOOR_RST   = SAMPLE_BITS'(10000);
  localparam logic [SAMPLE_BITS-1:0] SEED_FLOOR_RST     = SAMPLE_BITS'(50);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOUCH_MARGIN   = 3'd0,
    CFG_RELEASE_MARGIN = 3'd1,
    CFG_CONFIRM_FRAMES = 3'd2,
    CFG_DETECT_FLOOR   = 3'd3,
    CFG_SEED_FLOOR     = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    REQ_READING = 1'b0,
    REQ_CLEAR   = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic                   req_type;
    logic [SAMPLE_BITS-1:0] reading;
  } req_t;

  typedef struct packed {
    logic                   is_touched;
    logic                   state_changed;
    logic [SAMPLE_BITS-1:0] baseline_now;
    logic [SAMPLE_BITS-1:0] last_reading;
  } rsp_t;

  typedef struct packed {
    logic [MARGIN_W-1:0]    touch_margin;
    logic [MARGIN_W-1:0]    release_margin;
    logic [RUN_W-1:0]       confirm_frames;
    logic [SAMPLE_BITS-1:0] detect_floor;
    logic [SAMPLE_BITS-1:0] seed_floor;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] baseline;
    logic                   touched;
    logic [RUN_W-1:0]       high_run;
    logic [RUN_W-1:0]       low_run;
    logic [SAMPLE_BITS-1:0] held_reading;
  } trk_state_t;

endpackage

@@ sv/tdbt_update.sv @@
// ----------------------------------------------------------------------------
// Touch detector update
// Next tracking state and result for one transaction, purely combinational.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdbt_update import tdbt_pkg::*; (
  input  cfg_t       cfg,
  input  trk_state_t st,
  input  req_t       req,
  output trk_state_t st_nxt,
  output rsp_t       rsp
);

  localparam int SB = SAMPLE_BITS;

  function automatic logic [RUN_W-1:0] run_bump(input logic [RUN_W-1:0] v);
    return (&v) ? v : v + RUN_W'(1);
  endfunction

  logic [SB+4:0]       filt_sum;
  logic [SB-1:0]       base_new;
  logic [SB+16:0]      lhs;
  logic [SB+16:0]      touch_lim;
  logic [SB+16:0]      release_lim;
  logic [RUN_W-1:0]    need;
  logic                above;
  logic                below;

  // 15/16 filter: 15*b is formed as 16*b - b.
  assign filt_sum = {1'b0, st.baseline, 4'b0000} - {5'b00000, st.baseline}
                    + {5'b00000, req.reading};
  assign base_new = filt_sum[SB+3:4];

  // Exact Q0.16 threshold compares: reading*2^16 against baseline*(2^16+margin).
  assign lhs         = {1'b0, req.reading, 16'h0000};
  assign touch_lim   = base_new * {1'b1, cfg.touch_margin};
  assign release_lim = base_new * {1'b1, cfg.release_margin};
  assign above       = lhs > touch_lim;
  assign below       = lhs < release_lim;
  assign need        = (cfg.confirm_frames == '0) ? RUN_W'(1) : cfg.confirm_frames;

  always_comb begin
    st_nxt = st;
    if (req.req_type == REQ_CLEAR) begin
      st_nxt.baseline = '0;
    end else if (st.baseline == '0) begin
      // Seeding frame: only the baseline may change.
      if (req.reading > cfg.seed_floor) begin
        st_nxt.baseline = req.reading;
      end
    end else begin
      st_nxt.held_reading = req.reading;
      st_nxt.baseline     = base_new;
      if (base_new > cfg.detect_floor) begin
        if (above) begin
          st_nxt.high_run = run_bump(st.high_run);
          st_nxt.low_run  = '0;
        end else begin
          st_nxt.high_run = '0;
          st_nxt.low_run  = below ? run_bump(st.low_run) : '0;
        end
        if (!st_nxt.touched && st_nxt.high_run >= need) begin
          st_nxt.touched  = 1'b1;
          st_nxt.high_run = '0;
        end
        if (st_nxt.touched && st_nxt.low_run >= need) begin
          st_nxt.touched = 1'b0;
          st_nxt.low_run = '0;
        end
      end else begin
        st_nxt.touched  = 1'b0;
        st_nxt.high_run = '0;
        st_nxt.low_run  = '0;
      end
    end
  end

  assign rsp.is_touched    = st_nxt.touched;
  assign rsp.state_changed = st_nxt.touched ^ st.touched;
  assign rsp.baseline_now  = st_nxt.baseline;
  assign rsp.last_reading  = st_nxt.held_reading;

endmodule

@@ sv/touch_detect_with_baseline_tracking.sv @@
// ----------------------------------------------------------------------------
// Touch detector with baseline tracking
// Seeds and filters a baseline, then debounces touch and release decisions.
// ----------------------------------------------------------------------------
// Usage: each input transaction on in_* carries either a sensor reading or a
// clear-baseline command, and yields exactly one result transaction on out_*
// with the confirmed touch state, a change flag, the baseline and the last
// reading used for detection.
// An accepted transaction waits in the input register; then the filter,
// threshold multiply and debounce logic update the tracking state and load
// the result register, which drives out_valid. A new transaction is accepted
// every cycle while the receiver keeps up; the single input register and
// the single result register bound the throughput at one transaction per cycle.
// When the receiver stalls, the result register holds; the input register
// still takes one more transaction, and in_ready falls once both are full.
// The cfg_* port writes the threshold, debounce and floor registers and is
// always ready; write it only while no transaction is in flight.
// Reset restores the register defaults and clears the baseline, touch flag,
// run counters and held reading; there is no initialisation sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "touch_detect_with_baseline_tracking_assert.svh"

module touch_detect_with_baseline_tracking import tdbt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  req_t                  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rsp_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg_r;
  trk_state_t st_r;
  trk_state_t st_nxt;
  rsp_t       rsp_nxt;
  rsp_t       out_rsp_r;
  req_t       s1_req_r;
  logic       s1_valid_r;
  logic       out_valid_r;
  logic       s1_adv;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.touch_margin   <= TOUCH_MARGIN_RST;
      cfg_r.release_margin <= RELEASE_MARGIN_RST;
      cfg_r.confirm_frames <= CONFIRM_FRAMES_RST;
      cfg_r.detect_floor   <= DETECT_FLOOR_RST;
      cfg_r.seed_floor     <= SEED_FLOOR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TOUCH_MARGIN:   cfg_r.touch_margin   <= cfg_data[MARGIN_W-1:0];
        CFG_RELEASE_MARGIN: cfg_r.release_margin <= cfg_data[MARGIN_W-1:0];
        CFG_CONFIRM_FRAMES: cfg_r.confirm_frames <= cfg_data[RUN_W-1:0];
        CFG_DETECT_FLOOR:   cfg_r.detect_floor   <= cfg_data[SAMPLE_BITS-1:0];
        CFG_SEED_FLOOR:     cfg_r.seed_floor     <= cfg_data[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  tdbt_update u_update (
    .cfg    (cfg_r),
    .st     (st_r),
    .req    (s1_req_r),
    .st_nxt (st_nxt),
    .rsp    (rsp_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_req_r <= in_data;
    end
    if (s1_adv) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  `TDBT_ASSERT_NEXT(a_change_flag, clk, rst_n, s1_adv,
    out_rsp_r.state_changed == (out_rsp_r.is_touched != $past(st_r.touched)),
    "state_changed disagrees with the touch flag transition")
  `TDBT_ASSERT_NEXT(a_clear_zeroes, clk, rst_n,
    s1_adv && (s1_req_r.req_type == REQ_CLEAR),
    st_r.baseline == '0 && out_rsp_r.baseline_now == '0,
    "clear command did not zero the baseline")
  `TDBT_ASSERT_NEXT(a_seed_holds, clk, rst_n,
    s1_adv && (s1_req_r.req_type == REQ_READING) && (st_r.baseline == '0),
    $stable(st_r.held_reading) && $stable(st_r.touched),
    "seeding frame changed held reading or touch flag")
  `TDBT_ASSERT_NEXT(a_stage_hold, clk, rst_n, s1_valid_r && !s1_adv,
    s1_valid_r && $stable(s1_req_r),
    "input register lost or changed a waiting transaction")
  `TDBT_ASSERT_NOW(a_state_mirror, clk, rst_n, out_valid_r,
    out_rsp_r.baseline_now == st_r.baseline && out_rsp_r.is_touched == st_r.touched,
    "result register out of step with tracking state")

endmodule
